### rtl/sfpt_pkg.sv
// shared types and constants of the sign-flip paired t statistic block
`default_nettype none

package sfpt_pkg;

    localparam int MAX_SUBJECTS = 8;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 4;
    localparam int X_W          = DATA_W + 1;
    localparam int SQ_W         = 2 * DATA_W - 1;
    localparam int S_W          = X_W + 3;
    localparam int AS_W         = S_W - 1;
    localparam int Q_W          = SQ_W + 3;
    localparam int P_W          = 2 * AS_W;
    localparam int NUM_W        = P_W + 3;
    localparam int QUO_W        = 62;
    localparam int FRAC_SH      = 32;
    localparam int HEAD_SH      = QUO_W - FRAC_SH;
    localparam int BIT_W        = QUO_W + 1;
    localparam int ROOT_STEPS   = QUO_W / 2 + 1;
    localparam int STEP_W       = 5;
    localparam int MERGE_LAT    = 4;
    localparam int PIPE_LAT     = 1 + MERGE_LAT + QUO_W + ROOT_STEPS;

    // saturation bounds and the overflow magnitude, one bit wider than the data
    localparam logic signed [DATA_W:0] SAT_MAX = {2'b00, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W:0] SAT_MIN = {2'b11, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W:0]        MAG_OVF = {2'b01, {(DATA_W-1){1'b0}}};

    localparam logic CFG_SUBJECT_COUNT = 1'b0;
    localparam logic CFG_TWO_TAILED    = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] diff_0;
        logic signed [DATA_W-1:0] diff_1;
        logic signed [DATA_W-1:0] diff_2;
        logic signed [DATA_W-1:0] diff_3;
        logic signed [DATA_W-1:0] diff_4;
        logic signed [DATA_W-1:0] diff_5;
        logic signed [DATA_W-1:0] diff_6;
        logic signed [DATA_W-1:0] diff_7;
        logic [MAX_SUBJECTS-1:0]  sign_pattern;
        logic                     apply_signs;
        logic signed [DATA_W-1:0] observed_tail;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] mean_value;
        logic signed [DATA_W-1:0] t_value;
        logic signed [DATA_W-1:0] tail_stat;
        logic                     reaches_observed;
        logic                     zero_variance;
    } t_out_res;

    typedef struct packed {
        logic                     neg;
        logic                     szero;
        logic                     zvar;
        logic                     ovf;
        logic signed [DATA_W-1:0] obs;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [P_W-1:0]   d;
        logic [P_W-1:0]   rem;
        logic [QUO_W-1:0] w;
        logic [QUO_W-1:0] mw;
        logic [CNT_W-1:0] mrem;
    } t_div_st;

    typedef struct packed {
        t_side            side;
        logic [AS_W-1:0]  am;
        logic [QUO_W-1:0] v;
        logic [BIT_W-1:0] res;
    } t_sqrt_st;

endpackage

`default_nettype wire

### rtl/sign_flip_paired_t_statistic.sv
// top level of the sign-flip paired t statistic pipeline
//
// Requests enter on i_in_valid / o_in_ready with payload i_in_req: eight
// Q15.16 differences, a sign pattern, an apply flag and an observed tail
// value. Results leave on o_out_valid / i_out_ready with payload o_out_res.
// Configuration (subject count, two-tailed flag): i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write it only while idle (not enforced).
//
// Throughput: one request per cycle while o_in_ready is high. Eight lanes
// flip and square the differences side by side, the merge stages sum
// them, then a 62-stage restoring divider and a 32-stage square root
// pipeline form |t|. A request passes the lane, merge, divider and root
// registers in that order, then enters the output buffer.
//
// A two-entry output buffer sits behind the pipeline. The pipeline moves
// whenever that buffer is not full, so a request is still taken while one
// result waits; with both entries held, o_in_ready drops and the pipeline
// freezes until the receiver takes a result.
// Synchronous reset empties the pipeline and the buffer and restores the
// subject count to 8 and the two-tailed flag to 1.
`default_nettype none

module sign_flip_paired_t_statistic
    import sfpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_in_req          i_in_req,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_out_res              o_out_res,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_idx,
    input  wire logic [CNT_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0]         r_subj;
    logic                     r_two;
    logic [CNT_W-1:0]         w_n;
    logic                     w_adv;
    logic [PIPE_LAT-1:0]      r_vld;
    logic signed [DATA_W-1:0] w_diff [MAX_SUBJECTS];
    logic signed [X_W-1:0]    w_x    [MAX_SUBJECTS];
    logic [SQ_W-1:0]          w_sq   [MAX_SUBJECTS];
    logic signed [DATA_W-1:0] r_obs1;
    t_div_st                  w_div  [QUO_W+1];
    t_sqrt_st                 w_sqr  [ROOT_STEPS+1];
    t_out_res                 w_res;
    t_out_res                 r_buf  [2];
    logic                     r_wp;
    logic                     r_rp;
    logic [1:0]               r_cnt;
    logic                     w_push;
    logic                     w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_subj <= CNT_W'(MAX_SUBJECTS);
            r_two  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SUBJECT_COUNT: r_subj <= i_cfg_data;
                CFG_TWO_TAILED:    r_two  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_subj < CNT_W'(2)) begin
            w_n = CNT_W'(2);
        end else if (r_subj > CNT_W'(MAX_SUBJECTS)) begin
            w_n = CNT_W'(MAX_SUBJECTS);
        end else begin
            w_n = r_subj;
        end
    end

    assign w_adv      = (r_cnt != 2'd2);
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    assign w_diff[0] = i_in_req.diff_0;
    assign w_diff[1] = i_in_req.diff_1;
    assign w_diff[2] = i_in_req.diff_2;
    assign w_diff[3] = i_in_req.diff_3;
    assign w_diff[4] = i_in_req.diff_4;
    assign w_diff[5] = i_in_req.diff_5;
    assign w_diff[6] = i_in_req.diff_6;
    assign w_diff[7] = i_in_req.diff_7;

    for (genvar gi = 0; gi < MAX_SUBJECTS; gi++) begin : g_lane
        sfpt_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_diff (w_diff[gi]),
            .i_neg  (i_in_req.apply_signs & i_in_req.sign_pattern[gi]),
            .i_use  (CNT_W'(gi) < w_n),
            .o_x    (w_x[gi]),
            .o_sq   (w_sq[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_obs1 <= i_in_req.observed_tail;
        end
    end

    sfpt_merge u_merge (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_n   (w_n),
        .i_x   (w_x),
        .i_sq  (w_sq),
        .i_obs (r_obs1),
        .o_div (w_div[0])
    );

    for (genvar gd = 0; gd < QUO_W; gd++) begin : g_div
        sfpt_div_step u_div (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_n   (w_n),
            .i_st  (w_div[gd]),
            .o_st  (w_div[gd+1])
        );
    end

    assign w_sqr[0].side = w_div[QUO_W].side;
    assign w_sqr[0].am   = w_div[QUO_W].mw[AS_W-1:0];
    assign w_sqr[0].v    = w_div[QUO_W].w;
    assign w_sqr[0].res  = '0;

    for (genvar gs = 0; gs < ROOT_STEPS; gs++) begin : g_sqrt
        sfpt_sqrt_step u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_step (STEP_W'(gs)),
            .i_st   (w_sqr[gs]),
            .o_st   (w_sqr[gs+1])
        );
    end

    // sign, saturation and tail compare
    always_comb begin
        t_sqrt_st              f;
        logic [DATA_W:0]       mean_w;
        logic [DATA_W:0]       mag;
        logic signed [DATA_W:0] t_w;
        logic signed [DATA_W:0] a_w;
        logic signed [AS_W:0]  m_w;
        logic signed [DATA_W-1:0] t_s;
        logic signed [DATA_W-1:0] tail;
        f   = w_sqr[ROOT_STEPS];
        m_w = f.side.neg ? -(AS_W + 1)'(f.am) : (AS_W + 1)'(f.am);
        if (m_w > (AS_W + 1)'(SAT_MAX)) begin
            mean_w = SAT_MAX;
        end else if (m_w < (AS_W + 1)'(SAT_MIN)) begin
            mean_w = SAT_MIN;
        end else begin
            mean_w = m_w[DATA_W:0];
        end
        mag = f.side.ovf ? MAG_OVF : (DATA_W + 1)'(f.res);
        if (f.side.zvar || f.side.szero) begin
            t_w = '0;
        end else begin
            t_w = f.side.neg ? -$signed(mag) : $signed(mag);
        end
        if (t_w > SAT_MAX) begin
            t_s = SAT_MAX[DATA_W-1:0];
        end else begin
            t_s = t_w[DATA_W-1:0];
        end
        a_w = t_w[DATA_W] ? -t_w : t_w;
        if (!r_two) begin
            tail = t_s;
        end else if (a_w > SAT_MAX) begin
            tail = SAT_MAX[DATA_W-1:0];
        end else begin
            tail = a_w[DATA_W-1:0];
        end
        w_res.mean_value       = mean_w[DATA_W-1:0];
        w_res.t_value          = t_s;
        w_res.tail_stat        = tail;
        w_res.reaches_observed = (tail >= f.side.obs);
        w_res.zero_variance    = f.side.zvar;
    end

    // output buffer
    assign w_push      = w_adv & r_vld[PIPE_LAT-1];
    assign o_out_valid = (r_cnt != 2'd0);
    assign w_pop       = o_out_valid & i_out_ready;
    assign o_out_res   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

`default_nettype wire

### rtl/sfpt_lane.sv
// one subject lane: sign flip, masking and squaring of a difference
`default_nettype none

module sfpt_lane
    import sfpt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic signed [DATA_W-1:0] i_diff,
    input  wire logic                     i_neg,
    input  wire logic                     i_use,
    output logic signed [X_W-1:0]         o_x,
    output logic [SQ_W-1:0]               o_sq
);

    logic signed [X_W-1:0] r_x;
    logic signed [X_W-1:0] n_x;
    logic [SQ_W-1:0]       r_sq;
    logic [SQ_W-1:0]       n_sq;
    logic signed [X_W-1:0] w_ext;
    logic signed [X_W-1:0] w_abs;
    logic [DATA_W-1:0]     w_mag;
    logic [2*DATA_W-1:0]   w_prod;

    always_comb begin
        w_ext  = X_W'(i_diff);
        w_abs  = i_diff[DATA_W-1] ? -w_ext : w_ext;
        w_mag  = w_abs[DATA_W-1:0];
        w_prod = w_mag * w_mag;
        if (!i_use) begin
            n_x  = '0;
            n_sq = '0;
        end else begin
            n_x  = i_neg ? -w_ext : w_ext;
            n_sq = SQ_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= n_x;
            r_sq <= n_sq;
        end
    end

    assign o_x  = r_x;
    assign o_sq = r_sq;

endmodule

`default_nettype wire

### rtl/sfpt_merge.sv
// merge of the lanes: sums, variance numerator and divider setup
`default_nettype none

module sfpt_merge
    import sfpt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic [CNT_W-1:0]         i_n,
    input  wire logic signed [X_W-1:0]    i_x  [MAX_SUBJECTS],
    input  wire logic [SQ_W-1:0]          i_sq [MAX_SUBJECTS],
    input  wire logic signed [DATA_W-1:0] i_obs,
    output t_div_st                       o_div
);

    // sum stage
    logic signed [S_W-1:0]    r_s;
    logic signed [S_W-1:0]    n_s;
    logic [Q_W-1:0]           r_q;
    logic [Q_W-1:0]           n_q;
    logic signed [DATA_W-1:0] r_obs2;
    // square stage
    logic [AS_W-1:0]          r_md;
    logic [AS_W-1:0]          n_md;
    logic [AS_W-1:0]          w_as;
    logic [P_W-1:0]           r_s2;
    logic [P_W-1:0]           n_s2;
    logic [P_W-1:0]           r_nq;
    logic [P_W-1:0]           n_nq;
    t_side                    r_side3;
    t_side                    n_side3;
    // variance stage
    logic [P_W-1:0]           r_d;
    logic [P_W-1:0]           n_d;
    logic [NUM_W-1:0]         r_p;
    logic [NUM_W-1:0]         n_p;
    logic [AS_W-1:0]          r_md4;
    logic [CNT_W-1:0]         w_nm1;
    t_side                    r_side4;
    t_side                    n_side4;
    // divider setup stage
    t_div_st                  r_div;
    t_div_st                  n_div;

    always_comb begin
        n_s = '0;
        n_q = '0;
        for (int i = 0; i < MAX_SUBJECTS; i++) begin
            n_s = n_s + S_W'(i_x[i]);
            n_q = n_q + Q_W'(i_sq[i]);
        end
    end

    always_comb begin
        w_as          = r_s[S_W-1] ? AS_W'(-r_s) : AS_W'(r_s);
        n_s2          = w_as * w_as;
        n_nq          = r_q * i_n;
        n_md          = w_as + AS_W'(i_n >> 1);
        n_side3.neg   = r_s[S_W-1];
        n_side3.szero = (r_s == '0);
        n_side3.zvar  = 1'b0;
        n_side3.ovf   = 1'b0;
        n_side3.obs   = r_obs2;
    end

    always_comb begin
        w_nm1        = i_n - CNT_W'(1);
        n_side4      = r_side3;
        n_side4.zvar = (r_s2 >= r_nq);
        n_d          = n_side4.zvar ? '0 : r_nq - r_s2;
        n_p          = r_s2 * w_nm1;
    end

    always_comb begin
        n_div.side     = r_side4;
        n_div.side.ovf = (P_W'(r_p[NUM_W-1:HEAD_SH]) >= r_d);
        n_div.d        = r_d;
        n_div.rem      = P_W'(r_p[NUM_W-1:HEAD_SH]);
        n_div.w        = {r_p[HEAD_SH-1:0], FRAC_SH'(0)};
        n_div.mw       = QUO_W'(r_md4);
        n_div.mrem     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= n_s;
            r_q     <= n_q;
            r_obs2  <= i_obs;
            r_s2    <= n_s2;
            r_nq    <= n_nq;
            r_md    <= n_md;
            r_side3 <= n_side3;
            r_d     <= n_d;
            r_p     <= n_p;
            r_md4   <= r_md;
            r_side4 <= n_side4;
            r_div   <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

`default_nettype wire

### rtl/sfpt_div_step.sv
// one restoring division stage for the t quotient and the mean quotient
`default_nettype none

module sfpt_div_step
    import sfpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [CNT_W-1:0] i_n,
    input  wire t_div_st          i_st,
    output t_div_st               o_st
);

    t_div_st          r_st;
    t_div_st          n_st;
    logic [P_W:0]     w_rem2;
    logic [P_W:0]     w_sub;
    logic             w_qb;
    logic [CNT_W:0]   w_mrem2;
    logic [CNT_W:0]   w_msub;
    logic             w_mqb;

    always_comb begin
        n_st    = i_st;
        w_rem2  = {i_st.rem, i_st.w[QUO_W-1]};
        w_sub   = w_rem2 - {1'b0, i_st.d};
        w_qb    = (w_rem2 >= {1'b0, i_st.d});
        n_st.rem = w_qb ? w_sub[P_W-1:0] : w_rem2[P_W-1:0];
        n_st.w   = {i_st.w[QUO_W-2:0], w_qb};

        w_mrem2 = {i_st.mrem, i_st.mw[QUO_W-1]};
        w_msub  = w_mrem2 - {1'b0, i_n};
        w_mqb   = (w_mrem2 >= {1'b0, i_n});
        n_st.mrem = w_mqb ? w_msub[CNT_W-1:0] : w_mrem2[CNT_W-1:0];
        n_st.mw   = {i_st.mw[QUO_W-2:0], w_mqb};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

### rtl/sfpt_sqrt_step.sv
// one stage of the digit-by-digit integer square root
`default_nettype none

module sfpt_sqrt_step
    import sfpt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [STEP_W-1:0] i_step,
    input  wire t_sqrt_st          i_st,
    output t_sqrt_st               o_st
);

    t_sqrt_st           r_st;
    t_sqrt_st           n_st;
    logic [STEP_W:0]    w_sh;
    logic [BIT_W-1:0]   w_bit;
    logic [BIT_W:0]     w_trial;
    logic [BIT_W:0]     w_left;

    always_comb begin
        n_st    = i_st;
        w_sh    = {STEP_W'(ROOT_STEPS - 1) - i_step, 1'b0};
        w_bit   = BIT_W'(1) << w_sh;
        w_trial = {1'b0, i_st.res} + {1'b0, w_bit};
        w_left  = (BIT_W + 1)'(i_st.v) - w_trial;
        if ((BIT_W + 1)'(i_st.v) >= w_trial) begin
            n_st.v   = w_left[QUO_W-1:0];
            n_st.res = (i_st.res >> 1) + w_bit;
        end else begin
            n_st.res = i_st.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

`default_nettype wire

### rtl/sfpt_checker.sv
// port-level checks of the sign-flip paired t statistic block
`default_nettype none

module sfpt_checker
    import sfpt_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             o_in_ready,
    input wire t_in_req          i_in_req,
    input wire logic             o_out_valid,
    input wire logic             i_out_ready,
    input wire t_out_res         o_out_res,
    input wire logic             i_cfg_we,
    input wire logic             i_cfg_idx,
    input wire logic [CNT_W-1:0] i_cfg_data
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_zero_var_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.zero_variance |-> o_out_res.t_value == '0)
        else $error("t not zero with zero variance");

    a_tail_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.tail_stat == o_out_res.t_value)
            || (o_out_res.tail_stat == -o_out_res.t_value)
            || (o_out_res.t_value == DATA_W'(2**(DATA_W-1))
                && o_out_res.tail_stat == DATA_W'(2**(DATA_W-1) - 1)))
        else $error("tail statistic is neither t nor its magnitude");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_res))
        else $error("stalled result changed");

endmodule

bind sign_flip_paired_t_statistic sfpt_checker u_sfpt_checker (.*);

`default_nettype wire
